// ----- design/aoc_pkg.sv -----
// Package for the audio output conditioner.
// Widths, register indexes and reset values, and the Q5.23 saturation helper.
// No dependencies.
package aoc_pkg;

    localparam int SAMPLE_W  = 24;   // Q1.23 sample and PCM width
    localparam int COEF_W    = 24;   // unsigned Q1.23 coefficients and trim
    localparam int ACC_W     = 28;   // Q5.23 internal value
    localparam int MUL_A_W   = 30;   // signed operand of the shared multiplier
    localparam int MUL_P_W   = MUL_A_W + COEF_W + 1;
    localparam int Q_FRAC    = 23;
    localparam int MUL_R_W   = MUL_P_W - Q_FRAC;
    localparam int SUM_W     = 33;   // headroom for add-then-saturate
    localparam int DIV_Q_W   = 23;   // quotient is below unity
    localparam int DIV_D_W   = 27;   // divisor is a positive Q5.23 value
    localparam int DIV_CNT_W = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_Q_W - 1);

    localparam logic [COEF_W-1:0] Q_ONE    = 24'd8388608;
    localparam logic [COEF_W-1:0] TRIM_MAX = 24'hFFFFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DC_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HR_ENABLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_POLE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENV_ATTACK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENV_RELEASE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_ATTACK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_RELEASE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING      = 3'd7;

    // reset values
    localparam logic [COEF_W-1:0] RST_DC_POLE      = 24'd8379045;
    localparam logic [COEF_W-1:0] RST_ENV_ATTACK   = 24'd1174405;
    localparam logic [COEF_W-1:0] RST_ENV_RELEASE  = 24'd25166;
    localparam logic [COEF_W-1:0] RST_TRIM_ATTACK  = 24'd1677722;
    localparam logic [COEF_W-1:0] RST_TRIM_RELEASE = 24'd12583;
    localparam logic [COEF_W-1:0] RST_CEILING      = 24'd7717519;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(28'sh7FFFFFF);
        lo = SUM_W'(28'sh8000000);
        if (v > hi)
        begin
            return 28'sh7FFFFFF;
        end
        if (v < lo)
        begin
            return 28'sh8000000;
        end
        return v[ACC_W-1:0];
    endfunction

endpackage

// ----- design/aoc_ifs.sv -----
// Channel interfaces of the audio output conditioner: sample in, PCM out, config write.
// Depends on aoc_pkg for widths.
interface aoc_in_if
    import aoc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface aoc_out_if
    import aoc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       channel_out;
    logic signed [SAMPLE_W-1:0] pcm_out;

    modport source (output valid, output channel_out, output pcm_out, input ready);
    modport sink   (input valid, input channel_out, input pcm_out, output ready);
endinterface

interface aoc_cfg_if
    import aoc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/aoc_mul.sv -----
// Shared signed multiplier with registered product and round-half-up Q.23 output.
// Depends on aoc_pkg.
module aoc_mul
    import aoc_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic        [COEF_W-1:0]  b,
    output logic signed [MUL_R_W-1:0] r
);

    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] rounded;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(a) * MUL_P_W'($signed({1'b0, b}));
    end

    // floor((p + 2^22) / 2^23)
    assign rounded = prod_reg + MUL_P_W'(1 << (Q_FRAC - 1));
    assign r       = rounded[MUL_P_W-1:Q_FRAC];

endmodule

// ----- design/aoc_div.sv -----
// Restoring divider, one quotient bit a cycle: q = floor(dividend * 2^23 / divisor).
// Requires dividend < divisor. Depends on aoc_pkg.
module aoc_div
    import aoc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [COEF_W-1:0]   dividend,
    input  logic [DIV_D_W-1:0]  divisor,
    output logic                done,
    output logic [DIV_Q_W-1:0]  quotient
);

    logic                 run_reg,  run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [DIV_D_W-1:0]   rem_reg,  rem_next;
    logic [DIV_D_W-1:0]   dsr_reg,  dsr_next;
    logic [DIV_Q_W-1:0]   q_reg,    q_next;
    logic [DIV_D_W:0]     rem2;
    logic [DIV_D_W:0]     diff;
    logic                 ge;

    assign rem2 = {rem_reg, 1'b0};
    assign diff = rem2 - {1'b0, dsr_reg};
    assign ge   = rem2 >= {1'b0, dsr_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = DIV_D_W'(dividend);
            dsr_next = divisor;
            q_next   = '0;
        end
        else if (run_reg)
        begin
            // remainder stays below the divisor, so it fits back
            rem_next = ge ? diff[DIV_D_W-1:0] : rem2[DIV_D_W-1:0];
            q_next   = {q_reg[DIV_Q_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- design/audio_output_conditioner.sv -----
// Audio output conditioner top level: sequencer, state, config registers, output stage.
// Depends on aoc_pkg, aoc_ifs, aoc_mul and aoc_div.
//
// Takes one tagged Q1.23 sample at a time through a per-channel DC blocker, a shared
// envelope follower and an automatic gain trim, and returns one clamped 24-bit PCM
// sample per input. All products share one multiplier, each with an operand state
// and then a round-and-saturate state. The blocker and the headroom path (envelope,
// trim, scale) can each be switched off. When the envelope exceeds the ceiling, the
// bit-serial divider forms ceiling/envelope as the trim target. The next sample is
// taken as soon as the result is in the output register. Config writes are always
// accepted and must only be made while idle.
module audio_output_conditioner
    import aoc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    aoc_in_if.sink    samples,
    aoc_out_if.source results,
    aoc_cfg_if.sink   cfg
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DC_MUL    = 4'd1;
    localparam logic [3:0] S_DC_ADD    = 4'd2;
    localparam logic [3:0] S_ENV_MUL   = 4'd3;
    localparam logic [3:0] S_ENV_ADD   = 4'd4;
    localparam logic [3:0] S_DIV       = 4'd5;
    localparam logic [3:0] S_TRIM_MUL  = 4'd6;
    localparam logic [3:0] S_TRIM_ADD  = 4'd7;
    localparam logic [3:0] S_SCALE_MUL = 4'd8;
    localparam logic [3:0] S_SCALE_ADD = 4'd9;
    localparam logic [3:0] S_DONE      = 4'd10;

    logic [3:0] state_reg, state_next;

    // configuration
    logic              dc_en_reg, hr_en_reg;
    logic [COEF_W-1:0] pole_reg, env_atk_reg, env_rel_reg;
    logic [COEF_W-1:0] trim_atk_reg, trim_rel_reg, ceil_reg;

    // filter state
    logic signed [SAMPLE_W-1:0] x1_reg [2];
    logic signed [ACC_W-1:0]    y1_reg [2];
    logic signed [ACC_W-1:0]    env_reg, env_next;
    logic        [COEF_W-1:0]   trim_reg, trim_next;

    // item in flight
    logic                       ch_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [ACC_W-1:0]    y_reg, y_next;
    logic        [COEF_W-1:0]   target_reg, target_next;

    // output stage
    logic                       out_valid_reg;
    logic                       out_ch_reg;
    logic signed [SAMPLE_W-1:0] out_pcm_reg;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic        [COEF_W-1:0]  mul_b;
    logic signed [MUL_R_W-1:0] mul_r;
    logic                      div_start, div_done;
    logic        [DIV_Q_W-1:0] div_q;

    // datapath helpers
    logic signed [MUL_A_W-1:0]  y_ext, mag, env_ext, env_diff, trim_diff;
    logic signed [SUM_W-1:0]    dc_sum, env_sum, trim_sum, r_ext;
    logic signed [ACC_W-1:0]    dc_y;
    logic signed [ACC_W-1:0]    env_new;
    logic signed [ACC_W-1:0]    y_clamp;
    logic signed [ACC_W-1:0]    pcm_wide;
    logic                       env_above;
    logic                       in_xfer, out_free;

    aoc_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .r   (mul_r)
    );

    aoc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ceil_reg),
        .divisor  (env_new[DIV_D_W-1:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    assign samples.ready = (state_reg == S_IDLE);
    assign in_xfer       = samples.valid && samples.ready;
    assign out_free      = !out_valid_reg || results.ready;
    assign cfg.ready     = 1'b1;

    assign y_ext     = MUL_A_W'(y_reg);
    assign mag       = y_reg[ACC_W-1] ? -y_ext : y_ext;
    assign env_ext   = MUL_A_W'(env_reg);
    assign env_diff  = mag - env_ext;
    assign trim_diff = $signed(MUL_A_W'(target_reg)) - $signed(MUL_A_W'(trim_reg));
    assign r_ext     = SUM_W'(mul_r);

    assign dc_sum   = SUM_W'(x_reg) - SUM_W'(x1_reg[ch_reg]) + r_ext;
    assign dc_y     = sat_acc(dc_sum);
    assign env_sum  = SUM_W'(env_reg) + r_ext;
    assign env_new  = sat_acc(env_sum);
    assign trim_sum = $signed(SUM_W'(trim_reg)) + r_ext;

    // negative envelope never counts as above the ceiling
    assign env_above = $signed(MUL_A_W'(env_new)) > $signed(MUL_A_W'(ceil_reg));

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_DC_MUL:
            begin
                mul_a = MUL_A_W'(y1_reg[ch_reg]);
                mul_b = pole_reg;
            end
            S_ENV_MUL:
            begin
                mul_a = env_diff;
                mul_b = (mag > env_ext) ? env_atk_reg : env_rel_reg;
            end
            S_TRIM_MUL:
            begin
                mul_a = trim_diff;
                mul_b = (target_reg < trim_reg) ? trim_atk_reg : trim_rel_reg;
            end
            S_SCALE_MUL:
            begin
                mul_a = y_ext;
                mul_b = trim_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        env_next    = env_reg;
        trim_next   = trim_reg;
        y_next      = y_reg;
        target_next = target_reg;
        div_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    y_next = ACC_W'(samples.sample_in);
                    if (dc_en_reg)
                    begin
                        state_next = S_DC_MUL;
                    end
                    else if (hr_en_reg)
                    begin
                        state_next = S_ENV_MUL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DC_MUL:
            begin
                state_next = S_DC_ADD;
            end
            S_DC_ADD:
            begin
                y_next     = dc_y;
                state_next = hr_en_reg ? S_ENV_MUL : S_DONE;
            end
            S_ENV_MUL:
            begin
                state_next = S_ENV_ADD;
            end
            S_ENV_ADD:
            begin
                env_next = env_new;
                if (env_above)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    target_next = Q_ONE;
                    state_next  = S_TRIM_MUL;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    target_next = COEF_W'(div_q);
                    state_next  = S_TRIM_MUL;
                end
            end
            S_TRIM_MUL:
            begin
                state_next = S_TRIM_ADD;
            end
            S_TRIM_ADD:
            begin
                priority if (trim_sum < 0)
                begin
                    trim_next = '0;
                end
                else if (trim_sum > $signed(SUM_W'(TRIM_MAX)))
                begin
                    trim_next = TRIM_MAX;
                end
                else
                begin
                    trim_next = trim_sum[COEF_W-1:0];
                end
                state_next = S_SCALE_MUL;
            end
            S_SCALE_MUL:
            begin
                state_next = S_SCALE_ADD;
            end
            S_SCALE_ADD:
            begin
                y_next     = sat_acc(r_ext);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // clamp to +/- full scale, then step one LSB toward zero so the result fits 24 bits
    always_comb
    begin
        priority if (y_reg > $signed(ACC_W'(Q_ONE)))
        begin
            y_clamp = ACC_W'(Q_ONE);
        end
        else if (y_reg < -$signed(ACC_W'(Q_ONE)))
        begin
            y_clamp = -$signed(ACC_W'(Q_ONE));
        end
        else
        begin
            y_clamp = y_reg;
        end
        priority if (y_clamp > 0)
        begin
            pcm_wide = y_clamp - ACC_W'(1);
        end
        else if (y_clamp < 0)
        begin
            pcm_wide = y_clamp + ACC_W'(1);
        end
        else
        begin
            pcm_wide = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            env_reg       <= '0;
            trim_reg      <= Q_ONE;
            x1_reg[0]     <= '0;
            x1_reg[1]     <= '0;
            y1_reg[0]     <= '0;
            y1_reg[1]     <= '0;
            dc_en_reg     <= 1'b1;
            hr_en_reg     <= 1'b1;
            pole_reg      <= RST_DC_POLE;
            env_atk_reg   <= RST_ENV_ATTACK;
            env_rel_reg   <= RST_ENV_RELEASE;
            trim_atk_reg  <= RST_TRIM_ATTACK;
            trim_rel_reg  <= RST_TRIM_RELEASE;
            ceil_reg      <= RST_CEILING;
        end
        else
        begin
            state_reg <= state_next;
            env_reg   <= env_next;
            trim_reg  <= trim_next;

            if (state_reg == S_DC_ADD)
            begin
                x1_reg[ch_reg] <= x_reg;
                y1_reg[ch_reg] <= dc_y;
            end

            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_DC_ENABLE:    dc_en_reg    <= cfg.data[0];
                    CFG_HR_ENABLE:    hr_en_reg    <= cfg.data[0];
                    CFG_DC_POLE:      pole_reg     <= cfg.data;
                    CFG_ENV_ATTACK:   env_atk_reg  <= cfg.data;
                    CFG_ENV_RELEASE:  env_rel_reg  <= cfg.data;
                    CFG_TRIM_ATTACK:  trim_atk_reg <= cfg.data;
                    CFG_TRIM_RELEASE: trim_rel_reg <= cfg.data;
                    CFG_CEILING:      ceil_reg     <= cfg.data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg      <= y_next;
        target_reg <= target_next;
        if (in_xfer)
        begin
            ch_reg <= samples.channel;
            x_reg  <= samples.sample_in;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_ch_reg  <= ch_reg;
            out_pcm_reg <= pcm_wide[SAMPLE_W-1:0];
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.channel_out = out_ch_reg;
    assign results.pcm_out     = out_pcm_reg;

endmodule
